// File: sv/ramc_pkg.sv
// Shared constants, widths and operation codes for the rational add, multiply
// and compare block. Every other file of the block imports this package.
`default_nettype none

package ramc_pkg;

	localparam int OPERAND_WIDTH = 16;

	localparam int PROD_W = 2 * OPERAND_WIDTH;
	localparam int SUM_W  = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int SHIFT_W = $clog2(MAG_W + 1);
	localparam int COUNT_W = $clog2(MAG_W);

	localparam int TYPE_W = 2;
	localparam int NUM_W  = 33;
	localparam int DEN_W  = 32;

	typedef enum logic [TYPE_W-1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_CMP = 2'd2
	} op_t;

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
	typedef logic signed [PROD_W-1:0]        prod_t;
	typedef logic signed [SUM_W-1:0]         sum_t;
	typedef logic [MAG_W-1:0]                mag_t;

endpackage

`default_nettype wire

// File: sv/ramc_in_if.sv
// Request channel of the rational block: valid, ready, the operation type and the two fractions.
// Depends on ramc_pkg for the operand type.
`default_nettype none

interface ramc_in_if import ramc_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	operand_t          a_num;
	operand_t          a_den;
	operand_t          b_num;
	operand_t          b_den;

	modport source (output valid, output req_type, output a_num, output a_den,
		output b_num, output b_den, input ready);
	modport sink (input valid, input req_type, input a_num, input a_den,
		input b_num, input b_den, output ready);

endinterface

`default_nettype wire

// File: sv/ramc_out_if.sv
// Result channel of the rational block: valid, ready, the result fraction and the greater flag.
// Depends on ramc_pkg for the field widths.
`default_nettype none

interface ramc_out_if import ramc_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [NUM_W-1:0] res_num;
	logic signed [DEN_W-1:0] res_den;
	logic                    greater;

	modport source (output valid, output res_num, output res_den, output greater,
		input ready);
	modport sink (input valid, input res_num, input res_den, input greater,
		output ready);

endinterface

`default_nettype wire

// File: sv/ramc_mul.sv
// Shared signed multiplier with a registered product, used for every cross
// and denominator product in turn. Depends on ramc_pkg.
`default_nettype none

module ramc_mul import ramc_pkg::*; (
	input  logic     clk,
	input  operand_t x,
	input  operand_t y,
	output prod_t    p
);

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(x) * PROD_W'(y);
	end

	assign p = p_q;

endmodule

`default_nettype wire

// File: sv/ramc_gcd.sv
// Binary GCD of two positive magnitudes, one shift or subtract step a cycle.
// Depends on ramc_pkg.
`default_nettype none

module ramc_gcd import ramc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  mag_t u_in,
	input  mag_t v_in,
	output logic done,
	output mag_t g
);

	logic               busy_q;
	logic               done_q;
	mag_t               u_q;
	mag_t               v_q;
	mag_t               g_q;
	logic [SHIFT_W-1:0] k_q;
	logic [MAG_W:0]     u_minus_v;
	logic [MAG_W:0]     v_minus_u;

	assign u_minus_v = {1'b0, u_q} - {1'b0, v_q};
	assign v_minus_u = {1'b0, v_q} - {1'b0, u_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && (u_q == '0 || v_q == '0)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= u_in;
			v_q <= v_in;
			k_q <= '0;
		end else if (busy_q) begin
			if (u_q == '0 || v_q == '0) begin
				g_q <= (u_q | v_q) << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + SHIFT_W'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (!u_minus_v[MAG_W]) begin
				u_q <= u_minus_v[MAG_W:1];
			end else begin
				v_q <= v_minus_u[MAG_W:1];
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

`default_nettype wire

// File: sv/ramc_div.sv
// Restoring divider that divides numerator and denominator by the same GCD,
// one quotient bit of each per cycle. Depends on ramc_pkg.
`default_nettype none

module ramc_div import ramc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  mag_t n_in,
	input  mag_t d_in,
	input  mag_t divisor,
	output logic done,
	output mag_t n_quo,
	output mag_t d_quo
);

	logic               busy_q;
	logic               done_q;
	logic [COUNT_W-1:0] cnt_q;
	mag_t               div_q;
	mag_t               rn_q;
	mag_t               rd_q;
	mag_t               qn_q;
	mag_t               qd_q;
	logic [MAG_W:0]     tn;
	logic [MAG_W:0]     td;
	logic [MAG_W:0]     sn;
	logic [MAG_W:0]     sd;
	logic               last;

	assign tn   = {rn_q, qn_q[MAG_W-1]};
	assign td   = {rd_q, qd_q[MAG_W-1]};
	assign sn   = tn - {1'b0, div_q};
	assign sd   = td - {1'b0, div_q};
	assign last = (cnt_q == COUNT_W'(MAG_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + COUNT_W'(1);
			busy_q <= !last;
			done_q <= last;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rn_q  <= '0;
			rd_q  <= '0;
			qn_q  <= n_in;
			qd_q  <= d_in;
		end else if (busy_q) begin
			rn_q <= sn[MAG_W] ? tn[MAG_W-1:0] : sn[MAG_W-1:0];
			rd_q <= sd[MAG_W] ? td[MAG_W-1:0] : sd[MAG_W-1:0];
			qn_q <= {qn_q[MAG_W-2:0], !sn[MAG_W]};
			qd_q <= {qd_q[MAG_W-2:0], !sd[MAG_W]};
		end
	end

	assign done  = done_q;
	assign n_quo = qn_q;
	assign d_quo = qd_q;

endmodule

`default_nettype wire

// File: sv/rational_add_mul_compare_core.sv
// Top level of the rational add, multiply and compare block: sequencer,
// operand registers and result register. Depends on ramc_pkg, the channel
// interfaces, ramc_mul, ramc_gcd and ramc_div.
//
// The block takes one request at a time and holds ready low until it has
// finished it. A request passes through capture, the shared multiplier and a
// step forming the sum, product or comparison. Compare and unused requests,
// and results that are not both positive, then go straight to the result
// register. A result whose numerator and denominator are both positive is
// reduced: the binary GCD loop finds their common divisor and the divider
// then divides both by it. A finished result waits in its own register, so
// the next request can be taken while the previous result is still waiting
// to be read.
`default_nettype none

module rational_add_mul_compare_core import ramc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ramc_in_if.sink    req,
	ramc_out_if.source res
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_FORM = 6'b000100,
		ST_GCD  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t            state_q;
	logic [1:0]        cnt_q;
	logic [TYPE_W-1:0] op_q;
	operand_t          an_q;
	operand_t          ad_q;
	operand_t          bn_q;
	operand_t          bd_q;
	prod_t             p0_q;
	prod_t             p1_q;
	prod_t             den_q;
	sum_t              num_q;
	logic              gt_q;

	logic                    out_valid_q;
	logic signed [NUM_W-1:0] res_num_q;
	logic signed [DEN_W-1:0] res_den_q;
	logic                    greater_q;

	operand_t mul_x;
	operand_t mul_y;
	prod_t    mul_p;
	sum_t     sum_v;
	sum_t     num_v;
	logic     is_arith;
	logic     reduce;
	logic     out_free;

	logic gcd_start;
	logic gcd_done;
	mag_t gcd_g;
	logic div_done;
	mag_t div_n;
	mag_t div_d;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				mul_x = an_q;
				mul_y = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				mul_x = bn_q;
				mul_y = ad_q;
			end
			default: begin
				mul_x = ad_q;
				mul_y = bd_q;
			end
		endcase
	end

	ramc_mul u_mul (
		.clk (clk),
		.x   (mul_x),
		.y   (mul_y),
		.p   (mul_p)
	);

	assign sum_v     = SUM_W'(p0_q) + SUM_W'(p1_q);
	assign num_v     = (op_q == OP_ADD) ? sum_v : SUM_W'(p0_q);
	assign is_arith  = (op_q == OP_ADD) || (op_q == OP_MUL);
	assign reduce    = is_arith && (num_v > 0) && (den_q > 0);
	assign gcd_start = (state_q == ST_FORM) && reduce;
	assign out_free  = !out_valid_q || res.ready;

	ramc_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.u_in   (MAG_W'(num_v)),
		.v_in   (MAG_W'(den_q)),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	ramc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gcd_done),
		.n_in    (MAG_W'(num_q)),
		.d_in    (MAG_W'(den_q)),
		.divisor (gcd_g),
		.done    (div_done),
		.n_quo   (div_n),
		.d_quo   (div_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req.valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_FORM;
					end
				end
				ST_FORM: begin
					state_q <= reduce ? ST_GCD : ST_DONE;
				end
				ST_GCD: begin
					if (gcd_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q <= req.req_type;
			an_q <= req.a_num;
			bn_q <= req.b_num;
			ad_q <= (req.a_den == '0) ? OPERAND_WIDTH'(1) : req.a_den;
			bd_q <= (req.b_den == '0) ? OPERAND_WIDTH'(1) : req.b_den;
		end
		if (state_q == ST_MUL) begin
			case (cnt_q)
				2'd1:    p0_q  <= mul_p;
				2'd2:    p1_q  <= mul_p;
				2'd3:    den_q <= mul_p;
				default: ;
			endcase
		end
		if (state_q == ST_FORM) begin
			if (is_arith) begin
				num_q <= num_v;
				gt_q  <= 1'b0;
			end else begin
				num_q <= '0;
				den_q <= '0;
				gt_q  <= (op_q == OP_CMP) &&
					((ad_q == bd_q) ? (an_q > bn_q) : (p0_q > p1_q));
			end
		end
		if (state_q == ST_DIV && div_done) begin
			num_q <= {1'b0, div_n};
			den_q <= PROD_W'({1'b0, div_d});
		end
		if (state_q == ST_DONE && out_free) begin
			res_num_q <= NUM_W'(num_q);
			res_den_q <= DEN_W'(den_q);
			greater_q <= gt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req.ready   = (state_q == ST_IDLE);
	assign res.valid   = out_valid_q;
	assign res.res_num = res_num_q;
	assign res.res_den = res_den_q;
	assign res.greater = greater_q;

	a_greater_only_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.greater) |-> (res.res_num == '0 && res.res_den == '0))
		else $error("compare result carries a nonzero fraction");

	a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_done |-> (state_q == ST_GCD))
		else $error("GCD finished outside its state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished request");

endmodule

`default_nettype wire

// File: bench/ramc_result_checker.sv
// Result checker for the rational add, multiply and compare block.
// Watches both channel interfaces, predicts each result from the accepted request
// and compares it field by field. Depends on ramc_pkg and the two channel interfaces.

module ramc_result_checker import ramc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ramc_in_if   req,
	ramc_out_if  res,
	output int   errors,
	output int   outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
		logic                    gt;
	} fraction_t;

	fraction_t expected_fractions[$];
	int error_count = 0;
	int queued = 0;

	assign errors = error_count;
	assign outstanding = queued;

	function automatic fraction_t fraction_result(logic [TYPE_W-1:0] op, operand_t an_i,
			operand_t ad_i, operand_t bn_i, operand_t bd_i);
		longint an, ad, bn, bd, num, den, x, y, t;
		fraction_t r;
		an = an_i;
		ad = ad_i;
		bn = bn_i;
		bd = bd_i;
		r.num = '0;
		r.den = '0;
		r.gt = 1'b0;
		if (ad == 0)
			ad = 1;
		if (bd == 0)
			bd = 1;
		case (op)
			OP_ADD, OP_MUL: begin
				if (op == OP_ADD)
					num = an * bd + bn * ad;
				else
					num = an * bn;
				den = ad * bd;
				if (num > 0 && den > 0) begin
					x = num;
					y = den;
					while (y != 0) begin
						t = x % y;
						x = y;
						y = t;
					end
					num = num / x;
					den = den / x;
				end
				r.num = num[NUM_W-1:0];
				r.den = den[DEN_W-1:0];
			end
			OP_CMP: begin
				if (ad == bd)
					r.gt = an > bn;
				else
					r.gt = (an * bd) > (bn * ad);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		fraction_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_fractions.push_back(fraction_result(req.req_type, req.a_num,
					req.a_den, req.b_num, req.b_den));
			if (res.valid && res.ready) begin
				if (expected_fractions.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result num %0d den %0d greater %0b", $time,
						res.res_num, res.res_den, res.greater);
				end else begin
					want = expected_fractions.pop_front();
					if (res.res_num !== want.num) begin
						error_count++;
						$display("%0t: res_num expected %0d actual %0d", $time, want.num,
							res.res_num);
					end
					if (res.res_den !== want.den) begin
						error_count++;
						$display("%0t: res_den expected %0d actual %0d", $time, want.den,
							res.res_den);
					end
					if (res.greater !== want.gt) begin
						error_count++;
						$display("%0t: greater expected %0b actual %0b", $time, want.gt,
							res.greater);
					end
				end
			end
			queued = expected_fractions.size();
		end
	end

endmodule

// File: bench/rational_add_mul_compare_core_tb.sv
// Testbench top for the rational add, multiply and compare block: clock, reset,
// request stimulus, result back-pressure, watchdog and verdict. Depends on ramc_pkg,
// the channel interfaces, ramc_result_checker and the block itself.

module rational_add_mul_compare_core_tb import ramc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TYPE_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 395;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors;
	int outstanding;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	ramc_in_if  req_ch ();
	ramc_out_if res_ch ();

	rational_add_mul_compare_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	ramc_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic operand_t rand_value();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return -16'sd1;
					3: return 16'sd0;
					default: return 16'sd1;
				endcase
			end
			1, 2, 3, 4: return operand_t'($urandom_range(0, 80)) - operand_t'(40);
			default: return operand_t'($urandom);
		endcase
	endfunction

	function automatic operand_t rand_den();
		if ($urandom_range(9) == 0)
			return '0;
		return rand_value();
	endfunction

	task automatic send_req(input logic [TYPE_W-1:0] op, input operand_t an, input operand_t ad,
			input operand_t bn, input operand_t bd);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= op;
		req_ch.a_num <= an;
		req_ch.a_den <= ad;
		req_ch.b_num <= bn;
		req_ch.b_den <= bd;
		@(negedge clk);
		while (!req_ch.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		logic [TYPE_W-1:0] op;
		operand_t an, ad, bn, bd;
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 38)
				op = OP_ADD;
			else if (pick < 76)
				op = OP_MUL;
			else if (pick < 97)
				op = OP_CMP;
			else
				op = OP_UNUSED;
			an = rand_value();
			ad = rand_den();
			bn = rand_value();
			if (op == OP_CMP && $urandom_range(2) == 0)
				bd = ad;
			else
				bd = rand_den();
			send_req(op, an, ad, bn, bd);
		end
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.req_type <= OP_ADD;
		req_ch.a_num <= '0;
		req_ch.a_den <= '0;
		req_ch.b_num <= '0;
		req_ch.b_den <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
		send_req(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
		send_req(OP_MUL, 16'sd2, 16'sd4, 16'sd3, 16'sd6);
		send_req(OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_req(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_req(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_req(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_req(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_req(OP_MUL, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_req(OP_ADD, 16'sd3, 16'sd0, 16'sd4, 16'sd0);
		send_req(OP_MUL, 16'sd6, 16'sd0, 16'sd9, 16'sd4);
		send_req(OP_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd3);
		send_req(OP_ADD, -16'sd3, 16'sd4, 16'sd1, 16'sd4);
		send_req(OP_ADD, 16'sd3, -16'sd4, 16'sd1, 16'sd4);
		send_req(OP_CMP, 16'sd5, 16'sd7, 16'sd3, 16'sd7);
		send_req(OP_CMP, 16'sd5, -16'sd7, 16'sd3, -16'sd7);
		send_req(OP_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd3);
		send_req(OP_CMP, 16'sd1, -16'sd2, 16'sd2, 16'sd3);
		send_req(OP_CMP, 16'sd4, 16'sd6, 16'sd2, 16'sd3);
		send_req(OP_CMP, 16'sd5, 16'sd0, 16'sd4, 16'sd0);
		send_req(OP_CMP, 16'sh7fff, 16'sd1, 16'sh8000, 16'sd1);
		send_req(OP_CMP, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_req(OP_UNUSED, 16'sd5, 16'sd3, 16'sd2, 16'sd7);
		send_req(OP_UNUSED, 16'shffff, 16'shffff, 16'shffff, 16'shffff);

		hold_request = 1'b1;
		send_random(12);

		send_idle_pct = 0;
		stall_pct = 0;
		send_random(RANDOM_PER_PHASE);
		send_idle_pct = 52;
		stall_pct = 0;
		send_random(RANDOM_PER_PHASE);
		send_idle_pct = 0;
		stall_pct = 52;
		send_random(RANDOM_PER_PHASE);
		send_idle_pct = 29;
		stall_pct = 29;
		send_random(RANDOM_PER_PHASE);
		req_ch.valid <= 1'b0;
		stall_pct = 0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
